FILE: hw/rtl/tpft_pkg.sv
// ----------------------------------------------------------------------------
// tpft_pkg
// Shared types and constants for the tire pressure frame tracker.
// ----------------------------------------------------------------------------
package tpft_pkg;

  // Number of tracked wheel positions (2..8). Only positions 0..3 are reported.
  localparam int unsigned POSITIONS = 4;
  localparam int unsigned PosW      = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned SensW     = 2;
  localparam int unsigned NumSens   = 4;
  localparam int unsigned OutPos    = 4;

  localparam logic [10:0] PressureFrameId  = 11'h385;
  localparam logic [3:0]  PressureFrameLen = 4'd8;
  localparam logic [2:0]  ValidFlagTopBit  = 3'd7;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_SWAP    = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CAUSE_CHANGED  = 2'd0,
    CAUSE_REQUEST  = 2'd1,
    CAUSE_SWAP     = 2'd2,
    CAUSE_PERIODIC = 2'd3
  } cause_e;

  typedef struct packed {
    cmd_e                       command;
    logic [10:0]                can_id;
    logic [3:0]                 frame_length;
    logic [7:0]                 valid_flags;
    logic [NumSens-1:0][7:0]    sensor_byte;
    logic [3:0]                 swap_first;
    logic [3:0]                 swap_second;
  } item_t;

  typedef struct packed {
    logic [POSITIONS-1:0][7:0]       press;
    logic [POSITIONS-1:0][SensW-1:0] sensor_map;
    logic [15:0]                     ticks;
  } state_t;

  typedef struct packed {
    logic                     valid;
    cause_e                   cause;
    logic [OutPos-1:0][7:0]   pressure;
    logic [7:0]               position_map;
  } report_t;

endpackage

FILE: hw/rtl/tpft_update.sv
// ----------------------------------------------------------------------------
// tpft_update
// Evaluates one item against the tracker state: next state and report.
// ----------------------------------------------------------------------------
module tpft_update (
  input  tpft_pkg::state_t  st_i,
  input  tpft_pkg::item_t   item_i,
  input  logic [15:0]       period_i,
  output tpft_pkg::state_t  st_o,
  output tpft_pkg::report_t rep_o
);
  import tpft_pkg::*;

  state_t           st_w;
  logic             fire_w;
  cause_e           cause_w;
  logic             changed_w;
  logic [15:0]      ticks_inc_w;
  logic [PosW-1:0]  pa_w;
  logic [PosW-1:0]  pb_w;
  logic             swap_ok_w;

  assign pa_w = item_i.swap_first[PosW-1:0];
  assign pb_w = item_i.swap_second[PosW-1:0];
  assign swap_ok_w = ({28'd0, item_i.swap_first}  < 32'(POSITIONS)) &&
                     ({28'd0, item_i.swap_second} < 32'(POSITIONS)) &&
                     (item_i.swap_first != item_i.swap_second);
  assign ticks_inc_w = (st_i.ticks == 16'hFFFF) ? st_i.ticks : st_i.ticks + 16'd1;

  always_comb begin
    logic [SensW-1:0] s;
    logic [7:0]       v;
    s         = '0;
    v         = 8'd0;
    st_w      = st_i;
    fire_w    = 1'b0;
    cause_w   = CAUSE_CHANGED;
    changed_w = 1'b0;
    unique case (item_i.command)
      CMD_FRAME: begin
        if (item_i.can_id == PressureFrameId && item_i.frame_length == PressureFrameLen) begin
          for (int p = 0; p < POSITIONS; p++) begin
            s = st_i.sensor_map[p];
            v = item_i.valid_flags[ValidFlagTopBit - 3'(s)] ? item_i.sensor_byte[s] : 8'd0;
            if (st_i.press[p] != v) changed_w = 1'b1;
            st_w.press[p] = v;
          end
          fire_w  = changed_w;
          cause_w = CAUSE_CHANGED;
        end
      end
      CMD_REQUEST: begin
        fire_w  = 1'b1;
        cause_w = CAUSE_REQUEST;
      end
      CMD_SWAP: begin
        if (swap_ok_w) begin
          st_w.sensor_map[pa_w] = st_i.sensor_map[pb_w];
          st_w.sensor_map[pb_w] = st_i.sensor_map[pa_w];
          st_w.press[pa_w]      = st_i.press[pb_w];
          st_w.press[pb_w]      = st_i.press[pa_w];
          fire_w  = 1'b1;
          cause_w = CAUSE_SWAP;
        end
      end
      CMD_TICK: begin
        st_w.ticks = ticks_inc_w;
        if (period_i != 16'd0 && ticks_inc_w >= period_i) begin
          fire_w  = 1'b1;
          cause_w = CAUSE_PERIODIC;
        end
      end
      default: ;
    endcase
    if (fire_w) st_w.ticks = 16'd0;
  end

  assign st_o = st_w;

  always_comb begin
    rep_o.valid        = fire_w;
    rep_o.cause        = cause_w;
    rep_o.position_map = 8'd0;
    rep_o.pressure     = '0;
    for (int p = 0; p < OutPos; p++) begin
      if (p < POSITIONS) begin
        rep_o.pressure[p]             = st_w.press[p];
        rep_o.position_map[2*p +: 2]  = st_w.sensor_map[p];
      end
    end
  end

endmodule

FILE: hw/rtl/tire_pressure_frame_tracker.sv
// ----------------------------------------------------------------------------
// tire_pressure_frame_tracker
// Tracks four tire pressures from CAN frames, swap commands and time ticks.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word contents
// s_axis    in         tuser: command; tdata: frame, sensor bytes, swap positions
// m_axis    out        tuser: report cause; tdata: four pressures, position map
// cfg       in         report_period (16 bit), always ready
//
// An accepted word is captured in an input register, evaluated combinationally
// by the update logic and, if it causes a report, written to the result
// register. A new word is accepted every cycle; the only limit is the
// result register, which holds a report until the sink takes it.
// Reset clears the stored pressures and the tick counter, sets the position
// map to identity and clears report_period.
// Stalls on m_axis hold the update stage and, one word later, s_axis.
// ----------------------------------------------------------------------------
module tire_pressure_frame_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0 up: can_id[10:0], frame_length[14:11], valid_flags[22:15],
  // sensor_byte_0..3[54:23], swap_first[58:55], swap_second[62:59], zero[63].
  input  logic [tpft_pkg::InDataW-1:0]  s_axis_tdata,
  // Fields: command[1:0].
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0 up: pressure_0..3[31:0], position_map[39:32].
  output logic [tpft_pkg::OutDataW-1:0] m_axis_tdata,
  // Fields: report_cause[1:0].
  output logic [1:0]                    m_axis_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_data
);
  import tpft_pkg::*;

  // Input register.
  logic    in_valid_q;
  item_t   in_item_q, in_item_d;

  // Tracker state and configuration.
  state_t  st_q, st_d;
  logic [15:0] period_q;

  // Result register.
  logic    out_valid_q;
  report_t out_rep_q, rep_w;

  logic    advance_w;

  // The update stage moves whenever the result register is free or emptying.
  assign advance_w     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance_w;
  assign cfg_ready     = 1'b1;

  // Unpack the incoming word into its fields.
  always_comb begin
    in_item_d.command        = cmd_e'(s_axis_tuser);
    in_item_d.can_id         = s_axis_tdata[10:0];
    in_item_d.frame_length   = s_axis_tdata[14:11];
    in_item_d.valid_flags    = s_axis_tdata[22:15];
    for (int i = 0; i < NumSens; i++) begin
      in_item_d.sensor_byte[i] = s_axis_tdata[23 + 8*i +: 8];
    end
    in_item_d.swap_first     = s_axis_tdata[58:55];
    in_item_d.swap_second    = s_axis_tdata[62:59];
  end

  tpft_update u_update (
    .st_i     (st_q),
    .item_i   (in_item_q),
    .period_i (period_q),
    .st_o     (st_d),
    .rep_o    (rep_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      period_q    <= 16'd0;
      st_q.press  <= '0;
      st_q.ticks  <= 16'd0;
      for (int p = 0; p < POSITIONS; p++) begin
        st_q.sensor_map[p] <= SensW'(p % NumSens);
      end
    end else begin
      if (cfg_valid) period_q <= cfg_data;
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance_w) begin
        out_valid_q <= in_valid_q && rep_w.valid;
        if (in_valid_q) st_q <= st_d;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_item_q <= in_item_d;
    if (advance_w && in_valid_q && rep_w.valid) out_rep_q <= rep_w;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_rep_q.cause;
  always_comb begin
    m_axis_tdata[39:32] = out_rep_q.position_map;
    for (int p = 0; p < OutPos; p++) begin
      m_axis_tdata[8*p +: 8] = out_rep_q.pressure[p];
    end
  end

`ifndef NO_ASSERTIONS
  // Every report restarts the tick count.
  a_report_clears_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_w && in_valid_q && rep_w.valid |=> st_q.ticks == 16'd0)
    else $error("tick count not cleared by a report");

  // State only moves when an item is evaluated.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance_w && in_valid_q) |=> $stable(st_q))
    else $error("tracker state changed without an item");

  // A periodic report needs a non-zero period.
  a_periodic_needs_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rep_q.cause == CAUSE_PERIODIC |-> period_q != 16'd0)
    else $error("periodic report with period zero");
`endif

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tire pressure frame tracker. Words go in on
// s_axis in random bursts while m_axis stalls on a rotating ready pattern.
// A scoreboard mirrors the tracker's pressures, position map and tick count,
// and checks every report field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpft_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 8;   // input register + update + result register, with margin
  localparam int unsigned PhaseWords  = 136;

  // One input word in field form. sensor_byte[0] sits in the lowest byte.
  typedef struct {
    cmd_e             command;
    logic [10:0]      can_id;
    logic [3:0]       frame_length;
    logic [7:0]       valid_flags;
    logic [3:0][7:0]  sensor_byte;
    logic [3:0]       swap_first;
    logic [3:0]       swap_second;
  } word_t;

  // One report as the tracker should present it on m_axis.
  typedef struct {
    logic [3:0][7:0]  pressure;
    logic [7:0]       position_map;
    cause_e           cause;
  } tire_report_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the tracker state and a queue of the
  // reports that are still owed, oldest first.
  // --------------------------------------------------------------------------
  class tire_report_model;
    logic [7:0]   pressure [POSITIONS];
    logic [1:0]   sensor_of [POSITIONS];
    logic [15:0]  ticks;
    logic [15:0]  period;
    tire_report_t owed_reports [$];
    int unsigned  errors;
    int unsigned  cause_count [4];

    function new();
      for (int p = 0; p < POSITIONS; p++) begin
        pressure[p]  = 8'h00;
        sensor_of[p] = 2'(p);
      end
      ticks  = 16'h0000;
      period = 16'h0000;
      errors = 0;
      foreach (cause_count[i]) cause_count[i] = 0;
    endfunction

    function void set_period(logic [15:0] value);
      period = value;
    endfunction

    function int unsigned outstanding();
      return owed_reports.size();
    endfunction

    // Snapshot the state into a report and restart the period.
    function void queue_report(cause_e cause);
      tire_report_t r;
      r.position_map = 8'h00;
      for (int p = 0; p < 4; p++) begin
        r.pressure[p] = (p < POSITIONS) ? pressure[p] : 8'h00;
        if (p < POSITIONS) r.position_map[2*p +: 2] = sensor_of[p];
      end
      r.cause = cause;
      owed_reports.push_back(r);
      ticks = 16'h0000;
    endfunction

    function void accept_word(word_t w);
      logic       changed;
      logic [7:0] value;
      logic [1:0] sensor;
      logic [7:0] held_press;
      logic [1:0] held_sensor;
      case (w.command)
        CMD_FRAME: begin
          if (w.can_id == PressureFrameId && w.frame_length == PressureFrameLen) begin
            changed = 1'b0;
            for (int p = 0; p < POSITIONS; p++) begin
              sensor = sensor_of[p];
              value  = w.valid_flags[ValidFlagTopBit - sensor] ? w.sensor_byte[sensor] : 8'h00;
              if (pressure[p] != value) begin
                pressure[p] = value;
                changed     = 1'b1;
              end
            end
            if (changed) queue_report(CAUSE_CHANGED);
          end
        end
        CMD_REQUEST: queue_report(CAUSE_REQUEST);
        CMD_SWAP: begin
          if (w.swap_first < POSITIONS && w.swap_second < POSITIONS &&
              w.swap_first != w.swap_second) begin
            held_sensor             = sensor_of[w.swap_first];
            sensor_of[w.swap_first]  = sensor_of[w.swap_second];
            sensor_of[w.swap_second] = held_sensor;
            held_press              = pressure[w.swap_first];
            pressure[w.swap_first]   = pressure[w.swap_second];
            pressure[w.swap_second]  = held_press;
            queue_report(CAUSE_SWAP);
          end
        end
        default: begin
          // Time tick: the count saturates rather than wrapping.
          if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
          if (period != 16'h0000 && ticks >= period) queue_report(CAUSE_PERIODIC);
        end
      endcase
    endfunction

    task log_mismatch(string what);
      errors++;
      if (errors <= 20) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_report(logic [OutDataW-1:0] data, logic [1:0] user);
      tire_report_t r;
      if (owed_reports.size() == 0) begin
        log_mismatch($sformatf("report %h/%0d arrived with nothing owed", data, user));
        return;
      end
      r = owed_reports.pop_front();
      cause_count[r.cause]++;
      for (int p = 0; p < 4; p++)
        if (data[8*p +: 8] !== r.pressure[p])
          log_mismatch($sformatf("pressure_%0d got %h, want %h", p, data[8*p +: 8], r.pressure[p]));
      if (data[39:32] !== r.position_map)
        log_mismatch($sformatf("position_map got %h, want %h", data[39:32], r.position_map));
      if (user !== r.cause)
        log_mismatch($sformatf("report_cause got %0d, want %0d", user, r.cause));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block signals. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [15:0]         cfg_data      = '0;

  tire_report_model model = new();

  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned periods_set = 0;

  // Last well-formed frame content, reused so that unchanged frames show up.
  logic [7:0]      last_flags = 8'h00;
  logic [3:0][7:0] last_bytes = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  tire_pressure_frame_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Receiver: ready follows an eight-bit pattern that is redrawn whenever a
  // random countdown runs out. About a third of the patterns are all ones,
  // which gives long stretches without back-pressure. Bit 0 is always set so
  // the sink never stalls forever.
  // --------------------------------------------------------------------------
  logic [7:0]  ready_pattern = 8'hFF;
  logic [2:0]  pattern_pos   = 3'd0;
  int unsigned pattern_left  = 0;

  always @(posedge clk_i) begin
    if (pattern_left == 0) begin
      pattern_left  <= $urandom_range(20, 200);
      ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      pattern_left <= pattern_left - 1;
    end
    pattern_pos   <= pattern_pos + 3'd1;
    m_axis_tready <= ready_pattern[pattern_pos];
  end

  // Each report word taken by the sink is checked against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) model.check_report(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog on the cycle counter.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Run stopped at the cycle limit with %0d reports owed.", model.outstanding());
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks. All start and end on a rising edge.
  // --------------------------------------------------------------------------

  // Bursts of back-to-back words separated by random gaps. Roughly one burst
  // in four is followed by no gap at all.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Present one word and hold it until the tracker takes it.
  task automatic send_word(word_t w);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.command;
    s_axis_tdata  <= {1'b0, w.swap_second, w.swap_first, w.sensor_byte,
                      w.valid_flags, w.frame_length, w.can_id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model.accept_word(w);
    words_sent++;
    pace_sender();
  endtask

  // Stop sending and wait until every owed report is out; words that cause no
  // report may still be in flight, so the task then waits DrainCycles edges more.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (model.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_period(logic [15:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    model.set_period(value);
    periods_set++;
  endtask

  function automatic word_t plain_word(cmd_e command);
    word_t w;
    w.command      = command;
    w.can_id       = '0;
    w.frame_length = '0;
    w.valid_flags  = '0;
    w.sensor_byte  = '0;
    w.swap_first   = '0;
    w.swap_second  = '0;
    return w;
  endfunction

  function automatic word_t frame_word(logic [10:0] id, logic [3:0] len, logic [7:0] flags,
                                       logic [3:0][7:0] bytes);
    word_t w;
    w              = plain_word(CMD_FRAME);
    w.can_id       = id;
    w.frame_length = len;
    w.valid_flags  = flags;
    w.sensor_byte  = bytes;
    return w;
  endfunction

  function automatic word_t swap_word(logic [3:0] first, logic [3:0] second);
    word_t w;
    w             = plain_word(CMD_SWAP);
    w.swap_first  = first;
    w.swap_second = second;
    return w;
  endfunction

  // Random word: every field is filled with noise, then most words are shaped
  // into something the tracker acts on. Well-formed frames reuse the previous
  // content now and then so that unchanged frames are common too.
  function automatic word_t random_word();
    word_t       w;
    int unsigned pick;
    int unsigned first;
    w.command      = cmd_e'($urandom_range(0, 3));
    w.can_id       = 11'($urandom);
    w.frame_length = 4'($urandom);
    w.valid_flags  = 8'($urandom);
    w.sensor_byte  = 32'($urandom);
    w.swap_first   = 4'($urandom);
    w.swap_second  = 4'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.command = CMD_FRAME;
      if ($urandom_range(0, 99) < 80) begin
        w.can_id       = PressureFrameId;
        w.frame_length = PressureFrameLen;
        if ($urandom_range(0, 99) < 30) begin
          w.valid_flags = last_flags;
          w.sensor_byte = last_bytes;
        end else if ($urandom_range(0, 3) == 0) begin
          w.valid_flags = 8'hF0;
        end
        last_flags = w.valid_flags;
        last_bytes = w.sensor_byte;
      end
    end else if (pick < 55) begin
      w.command = CMD_REQUEST;
    end else if (pick < 75) begin
      w.command = CMD_SWAP;
      if ($urandom_range(0, 99) < 80) begin
        first         = $urandom_range(0, POSITIONS - 1);
        w.swap_first  = 4'(first);
        w.swap_second = 4'((first + $urandom_range(1, POSITIONS - 1)) % POSITIONS);
      end
    end else begin
      w.command = CMD_TICK;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] phase_periods [6];
    word_t       settled_frame;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, period at its reset value of zero.
    send_word(plain_word(CMD_REQUEST));                                  // reset state
    send_word(frame_word(PressureFrameId, PressureFrameLen, 8'hF0, 32'hFFFFFFFF));
    send_word(frame_word(PressureFrameId, PressureFrameLen, 8'hF0, 32'hFFFFFFFF)); // no change
    send_word(frame_word(PressureFrameId, PressureFrameLen, 8'h00, 32'hFFFFFFFF)); // all invalid
    send_word(frame_word(PressureFrameId, PressureFrameLen, 8'hA0, 32'h7FFE8001)); // sensors 0, 2
    // Frames that must be dropped: wrong identifier or wrong length.
    send_word(frame_word(11'h384, PressureFrameLen, 8'hF0, 32'h12345678));
    send_word(frame_word(11'h7FF, PressureFrameLen, 8'hFF, 32'hFFFFFFFF));
    send_word(frame_word(11'h000, PressureFrameLen, 8'hF0, 32'h01010101));
    send_word(frame_word(PressureFrameId, 4'd0, 8'hF0, 32'h11223344));
    send_word(frame_word(PressureFrameId, 4'hF, 8'hF0, 32'h11223344));
    send_word(frame_word(PressureFrameId, 4'd7, 8'hF0, 32'h11223344));
    // Only the low flag bits set, so every sensor reads as invalid.
    send_word(frame_word(PressureFrameId, PressureFrameLen, 8'h0F, 32'hCC33AA55));
    send_word(frame_word(PressureFrameId, PressureFrameLen, 8'hF0, 32'hCC33AA55));
    // Good swaps, both orders, then the bad ones: equal and out of range.
    send_word(swap_word(4'd0, 4'd1));
    send_word(swap_word(4'd3, 4'd2));
    send_word(swap_word(4'd1, 4'd2));
    send_word(swap_word(4'd0, 4'd3));
    send_word(swap_word(4'd2, 4'd2));
    send_word(swap_word(4'd4, 4'd1));
    send_word(swap_word(4'd0, 4'hF));
    // A frame after swapping must follow the new map.
    settled_frame = frame_word(PressureFrameId, PressureFrameLen, 8'hF0, 32'h40302010);
    send_word(settled_frame);
    send_word(plain_word(CMD_TICK));                                     // period off
    send_word(plain_word(CMD_TICK));

    // Shortest period: every tick reports.
    write_period(16'd1);
    send_word(plain_word(CMD_TICK));
    send_word(plain_word(CMD_TICK));

    // Period of three: a request restarts the count and an unchanged frame
    // leaves it alone, so only the third tick after the request reports.
    write_period(16'd3);
    send_word(plain_word(CMD_TICK));
    send_word(plain_word(CMD_TICK));
    send_word(plain_word(CMD_REQUEST));
    send_word(plain_word(CMD_TICK));
    send_word(plain_word(CMD_TICK));
    send_word(settled_frame);
    send_word(plain_word(CMD_TICK));

    // Reporting off, then the largest period: a couple of ticks stay far
    // below it and give no report.
    write_period(16'd0);
    write_period(16'hFFFF);
    send_word(plain_word(CMD_TICK));
    send_word(plain_word(CMD_TICK));

    // Random part in phases, each under its own period.
    phase_periods[0] = 16'd2;
    phase_periods[1] = 16'd1;
    phase_periods[2] = 16'hFFFF;
    phase_periods[3] = 16'($urandom_range(3, 40));
    phase_periods[4] = 16'd0;
    phase_periods[5] = 16'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      write_period(phase_periods[ph]);
      for (int n = 0; n < PhaseWords; n++) begin
        // Once, the sender holds off until the sink has drained everything.
        if (ph == 1 && n == PhaseWords / 2) settle();
        send_word(random_word());
      end
    end

    settle();
    $display("Covered %0d words under %0d period settings, shortest to longest.",
             words_sent, periods_set);
    $display("Reports checked: %0d changed, %0d request, %0d swap, %0d periodic.",
             model.cause_count[CAUSE_CHANGED], model.cause_count[CAUSE_REQUEST],
             model.cause_count[CAUSE_SWAP], model.cause_count[CAUSE_PERIODIC]);
    if (model.errors == 0 && model.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: tire_pressure_frame_tracker.f
hw/rtl/tpft_pkg.sv
hw/rtl/tpft_update.sv
hw/rtl/tire_pressure_frame_tracker.sv
bench/tb_top.sv
